[sv/chtab_pkg.sv]
// ----------------------------------------------------------------------------
// chtab_pkg: shared types for the counting hash table
// Beat payloads, command codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package chtab_pkg;

  // Command codes of an input beat
  localparam logic CMD_INCR = 1'b0;
  localparam logic CMD_GET  = 1'b1;

  // Count and byte accounting limits
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [13:0] BYTE_MAX  = 14'h3FFF;
  localparam logic [3:0]  LEN_MAX   = 4'd8;
  localparam logic [3:0]  ENTRY_OVERHEAD = 4'd5;  // 4 bytes count plus terminator

  typedef struct packed {
    logic        command;
    logic [63:0] key;
    logic [3:0]  key_length;
  } in_t;

  typedef struct packed {
    logic [31:0] count;
    logic        found;
    logic        inserted;
    logic        table_full;
    logic [10:0] entry_total;
    logic [13:0] byte_total;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_step;    // write one empty marker into the head table
    logic load;        // capture an input beat
    logic hash_step;   // one byte of the bucket remainder
    logic head_latch;  // take the bucket head as first node
    logic walk_step;   // follow the next link
    logic upd_found;   // bump the found count unless a get, set result
    logic fin_miss;    // set the result of a miss without insert
    logic ins_entry;   // write the new entry at the free slot
    logic ins_link;    // link the new entry, bump totals, set result
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic at_end;      // chain end or walk bound reached
    logic key_hit;
    logic get_cmd;
    logic full;
  } sts_t;

endpackage

`default_nettype wire

[sv/chtab_ram.sv]
// ----------------------------------------------------------------------------
// chtab_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/chtab_ctrl.sv]
// ----------------------------------------------------------------------------
// chtab_ctrl: sequencer of the counting hash table
// Clears the head table after reset, then runs hash, chain walk and update.
// ----------------------------------------------------------------------------
`default_nettype none

module chtab_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_valid,
  output chtab_pkg::ctl_t    ctl,
  input  wire chtab_pkg::sts_t sts
);

  import chtab_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_LATCH, S_CHK, S_CMP, S_FOUND, S_INSERT, S_LINK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    ctl           = '0;
    case (state_r)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        ctl.hash_step = 1'b1;
        if (sts.hash_last) state_nxt = S_HEAD;
      end
      S_HEAD: state_nxt = S_LATCH;
      S_LATCH: begin
        ctl.head_latch = 1'b1;
        state_nxt      = S_CHK;
      end
      S_CHK: begin
        if (!sts.at_end) begin
          state_nxt = S_CMP;
        end else if (sts.get_cmd || sts.full) begin
          ctl.fin_miss  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_CMP: begin
        if (sts.key_hit) begin
          state_nxt = S_FOUND;
        end else begin
          ctl.walk_step = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_FOUND: begin
        ctl.upd_found = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_INSERT: begin
        ctl.ins_entry = 1'b1;
        state_nxt     = S_LINK;
      end
      S_LINK: begin
        ctl.ins_link  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe outside idle");
  a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == S_HASH)
    else $error("accepted beat did not start hashing");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r)
    else $error("result during clearing pass");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.clr_step, ctl.upd_found, ctl.ins_entry, ctl.ins_link, ctl.fin_miss}))
    else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

[sv/chtab_dpath.sv]
// ----------------------------------------------------------------------------
// chtab_dpath: datapath of the counting hash table
// Bucket remainder, head and entry memories, chain registers and totals.
// ----------------------------------------------------------------------------
`default_nettype none

module chtab_dpath #(
  parameter int BUCKETS  = 256,
  parameter int ENTRIES  = 1024,
  parameter int KEY_BITS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire chtab_pkg::in_t  in_data,
  input  wire chtab_pkg::ctl_t ctl,
  output chtab_pkg::sts_t      sts,
  output chtab_pkg::out_t      out_data
);

  import chtab_pkg::*;

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EAW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW    = $clog2(ENTRIES + 1);
  localparam int STEPS = (KEY_BITS + 7) / 8;
  localparam int KPAD  = STEPS * 8;
  localparam int SW    = $clog2(STEPS + 1);
  localparam logic [LW-1:0] NIL     = LW'(ENTRIES);
  localparam logic [BW:0]   BMOD    = (BW + 1)'(BUCKETS);
  localparam logic [BW-1:0] BLAST   = BW'(BUCKETS - 1);
  localparam logic [SW-1:0] SLAST   = SW'(STEPS - 1);

  logic [BW-1:0]       clr_idx_r;
  logic                get_r;
  logic [KEY_BITS-1:0] key_r;
  logic [3:0]          len_r;
  logic [KPAD-1:0]     key_sh_r;
  logic [SW-1:0]       step_r;
  logic [BW-1:0]       rem_r, rem_nxt;
  logic [LW-1:0]       node_r, prev_r, hops_r;
  logic [LW-1:0]       used_r;
  logic [13:0]         bytes_r;
  out_t                res_r;

  logic [LW-1:0]       head_rdata, next_rdata;
  logic [KEY_BITS-1:0] key_rdata;
  logic [31:0]         count_rdata;

  // one byte of the remainder: eight shift and reduce steps
  always_comb begin
    logic [BW:0] r;
    logic [7:0]  byte_in;
    byte_in = key_sh_r[KPAD-1 -: 8];
    r = {1'b0, rem_r};
    for (int i = 7; i >= 0; i--) begin
      r = {r[BW-1:0], byte_in[i]};
      if (r >= BMOD) r = r - BMOD;
    end
    rem_nxt = r[BW-1:0];
  end

  // memory write selection
  logic          head_we, next_we, key_we, count_we;
  logic [BW-1:0] head_waddr;
  logic [LW-1:0] head_wdata, next_wdata;
  logic [EAW-1:0] next_waddr, count_waddr, node_addr, slot_addr, prev_addr;
  logic [31:0]   count_wdata, count_inc;

  assign node_addr = node_r[EAW-1:0];
  assign slot_addr = used_r[EAW-1:0];
  assign prev_addr = prev_r[EAW-1:0];
  assign count_inc = (count_rdata == COUNT_MAX) ? COUNT_MAX : count_rdata + 32'd1;

  always_comb begin
    head_we     = ctl.clr_step || (ctl.ins_link && prev_r == NIL);
    head_waddr  = ctl.clr_step ? clr_idx_r : rem_r;
    head_wdata  = ctl.clr_step ? NIL : used_r;
    next_we     = ctl.ins_entry || (ctl.ins_link && prev_r != NIL);
    next_waddr  = ctl.ins_entry ? slot_addr : prev_addr;
    next_wdata  = ctl.ins_entry ? NIL : used_r;
    key_we      = ctl.ins_entry;
    // a get leaves the stored count alone
    count_we    = ctl.ins_entry || (ctl.upd_found && !get_r);
    count_waddr = ctl.ins_entry ? slot_addr : node_addr;
    count_wdata = ctl.ins_entry ? 32'd1 : count_inc;
  end

  chtab_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(rem_r), .rdata(head_rdata)
  );
  chtab_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key (
    .clk(clk), .we(key_we), .waddr(slot_addr), .wdata(key_r),
    .raddr(node_addr), .rdata(key_rdata)
  );
  chtab_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_count (
    .clk(clk), .we(count_we), .waddr(count_waddr), .wdata(count_wdata),
    .raddr(node_addr), .rdata(count_rdata)
  );
  chtab_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(node_addr), .rdata(next_rdata)
  );

  // byte total after an insert, saturating
  logic [3:0]  len_clamp;
  logic [14:0] bytes_sum;
  logic [13:0] bytes_new;
  logic [31:0] used_ext;
  assign len_clamp = (len_r > LEN_MAX) ? LEN_MAX : len_r;
  assign bytes_sum = {1'b0, bytes_r} + 15'(ENTRY_OVERHEAD) + 15'(len_clamp);
  assign bytes_new = (bytes_sum > 15'(BYTE_MAX)) ? BYTE_MAX : bytes_sum[13:0];
  assign used_ext  = 32'(used_r + LW'(1));

  // control registers: clear index and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      used_r    <= '0;
      bytes_r   <= '0;
    end else begin
      if (ctl.clr_step) clr_idx_r <= clr_idx_r + BW'(1);
      if (ctl.ins_link) begin
        used_r  <= used_r + LW'(1);
        bytes_r <= bytes_new;
      end
    end
  end

  // item registers: key, remainder, chain position, result
  always_ff @(posedge clk) begin
    logic [31:0] tot;
    tot = 32'(used_r);
    if (ctl.load) begin
      get_r    <= in_data.command;
      key_r    <= in_data.key[KEY_BITS-1:0];
      len_r    <= in_data.key_length;
      key_sh_r <= KPAD'(in_data.key[KEY_BITS-1:0]);
      step_r   <= '0;
      rem_r    <= '0;
    end
    if (ctl.hash_step) begin
      rem_r    <= rem_nxt;
      key_sh_r <= key_sh_r << 8;
      step_r   <= step_r + SW'(1);
    end
    if (ctl.head_latch) begin
      node_r <= head_rdata;
      prev_r <= NIL;
      hops_r <= '0;
    end
    if (ctl.walk_step) begin
      prev_r <= node_r;
      node_r <= next_rdata;
      hops_r <= hops_r + LW'(1);
    end
    if (ctl.upd_found) begin
      res_r.count       <= get_r ? count_rdata : count_inc;
      res_r.found       <= 1'b1;
      res_r.inserted    <= 1'b0;
      res_r.table_full  <= 1'b0;
      res_r.entry_total <= tot[10:0];
      res_r.byte_total  <= bytes_r;
    end
    if (ctl.fin_miss) begin
      res_r.count       <= '0;
      res_r.found       <= 1'b0;
      res_r.inserted    <= 1'b0;
      res_r.table_full  <= !get_r;
      res_r.entry_total <= tot[10:0];
      res_r.byte_total  <= bytes_r;
    end
    if (ctl.ins_link) begin
      res_r.count       <= 32'd1;
      res_r.found       <= 1'b0;
      res_r.inserted    <= 1'b1;
      res_r.table_full  <= 1'b0;
      res_r.entry_total <= used_ext[10:0];
      res_r.byte_total  <= bytes_new;
    end
  end

  // status toward the controller
  always_comb begin
    sts.clr_last  = (clr_idx_r == BLAST);
    sts.hash_last = (step_r == SLAST);
    sts.at_end    = (node_r >= NIL) || (hops_r == NIL);
    sts.key_hit   = (key_rdata == key_r);
    sts.get_cmd   = (get_r == CMD_GET);
    sts.full      = (used_r == NIL);
  end

  assign out_data = res_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NIL)
    else $error("entry total beyond table size");
  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_entry |-> used_r != NIL)
    else $error("insert into full table");
  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins_link |=> used_r == $past(used_r) + LW'(1))
    else $error("entry total did not advance on insert");
`endif

endmodule

`default_nettype wire

[sv/counting_hash_table.sv]
// ----------------------------------------------------------------------------
// counting_hash_table: key-to-count table with chained buckets
// Increment and get commands on 64-bit keys, bucket = key mod BUCKETS.
//
//   channel  ports                      handshake
//   input    in_data (in_t)             start && !busy
//   result   out_data (out_t)           out_valid, one cycle, no backpressure
//
// Per item: the remainder over the key bytes (one byte a cycle), then the
// bucket head read and latch, then per chain link visited an entry memory
// read then compare, then a found update or a miss, or the entry write and
// link of an insert. After reset a clearing pass writes the empty marker
// into all BUCKETS head entries; busy stays high during it. The next item
// is accepted while a result is on the result ports.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_hash_table #(
  parameter int BUCKETS  = 256,
  parameter int ENTRIES  = 1024,
  parameter int KEY_BITS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire chtab_pkg::in_t  in_data,
  output logic                 out_valid,
  output chtab_pkg::out_t      out_data
);

  import chtab_pkg::*;

  ctl_t ctl;
  sts_t sts;

  chtab_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .ctl(ctl), .sts(sts)
  );

  chtab_dpath #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .ctl(ctl), .sts(sts),
    .out_data(out_data)
  );

endmodule

`default_nettype wire
